// ----- sv/tlb_fifo_page_translator_core_defines.svh -----
// Assertion macros used by the checker file of the page translator.
`ifndef TLB_FIFO_PAGE_TRANSLATOR_CORE_DEFINES_SVH
`define TLB_FIFO_PAGE_TRANSLATOR_CORE_DEFINES_SVH

// Checked at every edge outside reset.
`define TFPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define TFPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/tfpt_pkg.sv -----
// Constants, types and sequencer codes of the page translator.
package tfpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int PAGES       = 256;
  localparam int FRAMES      = 128;
  localparam int OFFSET_BITS = 8;

  localparam int ADDR_W    = 16;
  localparam int PAGE_W    = $clog2(PAGES);
  localparam int FRAME_W   = $clog2(FRAMES);
  localparam int TLB_IDX_W = $clog2(TLB_ENTRIES);
  localparam int USED_W    = $clog2(FRAMES + 1);
  localparam int PA_W      = FRAME_W + OFFSET_BITS;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [PAGE_W-1:0]      page_t;
  typedef logic [FRAME_W-1:0]     frame_t;
  typedef logic [OFFSET_BITS-1:0] offset_t;
  typedef logic [TLB_IDX_W-1:0]   tlb_idx_t;
  typedef logic [USED_W-1:0]      used_t;
  typedef logic [PA_W-1:0]        paddr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DECIDE,
    ST_EVICT
  } state_t;

  // Actions the sequencer orders in the current cycle.
  typedef struct packed {
    logic in_ready;
    logic load_out;
    logic tlb_hit;
    logic fault;
    logic tlb_fill;
    logic alloc;
    logic evict;
    logic key_old;
  } ctl_t;

  function automatic page_t page_of(input addr_t addr);
    logic [ADDR_W-OFFSET_BITS-1:0] hi;
    hi = addr[ADDR_W-1:OFFSET_BITS];
    return page_t'(hi % PAGES);
  endfunction

endpackage

// ----- sv/tfpt_if.sv -----
// Valid/ready channels carrying the address and the translation result.
interface tfpt_in_if;
  import tfpt_pkg::*;
  logic  valid;
  logic  ready;
  addr_t logical_address;
  modport source (output valid, output logical_address, input ready);
  modport sink (input valid, input logical_address, output ready);
endinterface

interface tfpt_out_if;
  import tfpt_pkg::*;
  logic   valid;
  logic   ready;
  paddr_t physical_address;
  frame_t frame_number;
  logic   tlb_hit;
  logic   page_fault;
  modport source (output valid, output physical_address, output frame_number,
                  output tlb_hit, output page_fault, input ready);
  modport sink (input valid, input physical_address, input frame_number,
                input tlb_hit, input page_fault, output ready);
endinterface

// ----- sv/tfpt_ram.sv -----
// Generic single write port RAM with a registered read port.
module tfpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/tlb_fifo_page_translator_core.sv -----
// Address translator: TLB in front of a page table with FIFO frame replacement.
//
//   channel  dir  payload                                               handshake
//   in_ch    in   logical_address[15:0]                                 valid/ready
//   out_ch   out  physical_address[14:0], frame_number[6:0],            valid/ready
//                 tlb_hit, page_fault
//
// An address passes through accept, TLB compare with page table read, and decide and write
// back, plus an evict step when a used frame must be evicted: that step reuses the TLB
// comparator against the victim page. The registered RAM reads and the registered TLB
// match require the compare step. Reset clears all valid bits at once, so no clearing pass.
// The result sits in an output register; a new address is taken while it waits,
// and the sequencer holds in the decide and evict steps while that register is full.
module tlb_fifo_page_translator_core (
  input logic       clk,
  input logic       rst_n,
  tfpt_in_if.sink   in_ch,
  tfpt_out_if.source out_ch
);
  import tfpt_pkg::*;

  state_t state_r, state_nxt;
  ctl_t   ctl;

  logic [TLB_ENTRIES-1:0] tlb_valid_r, tlb_valid_nxt;
  page_t                  tlb_page_r  [TLB_ENTRIES];
  frame_t                 tlb_frame_r [TLB_ENTRIES];
  tlb_idx_t               fill_ptr_r;
  logic [PAGES-1:0]       page_valid_r, page_valid_nxt;
  used_t                  frames_used_r;
  frame_t                 victim_r;

  page_t                  page_r;
  page_t                  key_r;
  offset_t                offset_r;
  logic [TLB_ENTRIES-1:0] cmp_vec;
  logic [TLB_ENTRIES-1:0] match_r;
  tlb_idx_t               hit_idx;

  frame_t pt_rdata;
  page_t  owner_rdata;
  frame_t frame_sel;
  logic   pool_full;
  logic   out_free;
  logic   any_hit;

  logic   out_valid_r;
  paddr_t out_pa_r;
  frame_t out_frame_r;
  logic   out_hit_r;
  logic   out_fault_r;

  // Shared comparator: every TLB entry against the current key page.
  always_comb begin
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      cmp_vec[i] = tlb_valid_r[i] && (tlb_page_r[i] == key_r);
    end
  end

  // The lowest numbered match wins.
  always_comb begin
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_idx = tlb_idx_t'(i);
      end
    end
  end

  assign any_hit   = |match_r;
  assign pool_full = (frames_used_r == used_t'(FRAMES));
  assign out_free  = !out_valid_r || out_ch.ready;

  tfpt_ram #(.WIDTH(FRAME_W), .DEPTH(PAGES)) u_page_frame (
    .clk   (clk),
    .we    (ctl.alloc || ctl.evict),
    .waddr (page_r),
    .wdata (frame_sel),
    .raddr (page_r),
    .rdata (pt_rdata)
  );

  tfpt_ram #(.WIDTH(PAGE_W), .DEPTH(FRAMES)) u_frame_owner (
    .clk   (clk),
    .we    (ctl.alloc || ctl.evict),
    .waddr (frame_sel),
    .wdata (page_r),
    .raddr (victim_r),
    .rdata (owner_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          if (any_hit || page_valid_r[page_r] || !pool_full) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_EVICT;
          end
        end
      end
      ST_EVICT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctl = '0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.in_ready = 1'b1;
      end
      ST_MATCH: begin
      end
      ST_DECIDE: begin
        if (out_free) begin
          if (any_hit) begin
            ctl.load_out = 1'b1;
            ctl.tlb_hit  = 1'b1;
          end else if (page_valid_r[page_r]) begin
            ctl.load_out = 1'b1;
            ctl.tlb_fill = 1'b1;
          end else if (!pool_full) begin
            ctl.load_out = 1'b1;
            ctl.tlb_fill = 1'b1;
            ctl.fault    = 1'b1;
            ctl.alloc    = 1'b1;
          end else begin
            ctl.key_old  = 1'b1;
          end
        end
      end
      ST_EVICT: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          ctl.tlb_fill = 1'b1;
          ctl.fault    = 1'b1;
          ctl.evict    = 1'b1;
        end
      end
      default: ctl = '0;
    endcase
  end

  always_comb begin
    if (ctl.tlb_hit) begin
      frame_sel = tlb_frame_r[hit_idx];
    end else if (ctl.alloc) begin
      frame_sel = frames_used_r[FRAME_W-1:0];
    end else if (ctl.evict) begin
      frame_sel = victim_r;
    end else begin
      frame_sel = pt_rdata;
    end
  end

  // The victim page's entries drop out before the new page is filled in.
  always_comb begin
    tlb_valid_nxt  = tlb_valid_r;
    page_valid_nxt = page_valid_r;
    if (ctl.evict) begin
      tlb_valid_nxt          = tlb_valid_r & ~cmp_vec;
      page_valid_nxt[key_r]  = 1'b0;
    end
    if (ctl.alloc || ctl.evict) begin
      page_valid_nxt[page_r] = 1'b1;
    end
    if (ctl.tlb_fill) begin
      tlb_valid_nxt[fill_ptr_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      tlb_valid_r   <= '0;
      fill_ptr_r    <= '0;
      page_valid_r  <= '0;
      frames_used_r <= '0;
      victim_r      <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tlb_valid_r  <= tlb_valid_nxt;
      page_valid_r <= page_valid_nxt;
      if (ctl.tlb_fill) begin
        fill_ptr_r <= (fill_ptr_r == tlb_idx_t'(TLB_ENTRIES - 1)) ? '0 : fill_ptr_r + 1'b1;
      end
      if (ctl.alloc) begin
        frames_used_r <= frames_used_r + 1'b1;
      end
      if (ctl.evict) begin
        victim_r <= (victim_r == frame_t'(FRAMES - 1)) ? '0 : victim_r + 1'b1;
      end
      if (ctl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.in_ready && in_ch.valid) begin
      page_r   <= page_of(in_ch.logical_address);
      key_r    <= page_of(in_ch.logical_address);
      offset_r <= in_ch.logical_address[OFFSET_BITS-1:0];
    end else if (ctl.key_old) begin
      key_r <= owner_rdata;
    end
    match_r <= cmp_vec;
    if (ctl.tlb_fill) begin
      tlb_page_r[fill_ptr_r]  <= page_r;
      tlb_frame_r[fill_ptr_r] <= frame_sel;
    end
    if (ctl.load_out) begin
      out_pa_r    <= {frame_sel, offset_r};
      out_frame_r <= frame_sel;
      out_hit_r   <= ctl.tlb_hit;
      out_fault_r <= ctl.fault;
    end
  end

  assign in_ch.ready             = ctl.in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.physical_address = out_pa_r;
  assign out_ch.frame_number     = out_frame_r;
  assign out_ch.tlb_hit          = out_hit_r;
  assign out_ch.page_fault       = out_fault_r;

endmodule

// ----- sv/tfpt_checker.sv -----
// Port-level checks of the page translator and their bind to the top level.
`include "tlb_fifo_page_translator_core_defines.svh"

module tfpt_checker (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input tfpt_pkg::paddr_t       out_physical_address,
  input tfpt_pkg::frame_t       out_frame_number,
  input logic                   out_tlb_hit,
  input logic                   out_page_fault
);
  import tfpt_pkg::*;

  `TFPT_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")
  `TFPT_ASSERT(a_out_held, out_valid && !out_ready |=> out_valid, "result dropped before transfer")
  `TFPT_ASSERT(a_hit_no_fault, out_valid |-> !(out_tlb_hit && out_page_fault), "hit and fault together")
  `TFPT_ASSERT(a_pa_frame, out_valid |-> out_physical_address[PA_W-1:OFFSET_BITS] == out_frame_number, "frame bits disagree")
  `TFPT_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "second address taken mid-translation")

endmodule

bind tlb_fifo_page_translator_core tfpt_checker u_tfpt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_ch.valid),
  .in_ready             (in_ch.ready),
  .out_valid            (out_ch.valid),
  .out_ready            (out_ch.ready),
  .out_physical_address (out_ch.physical_address),
  .out_frame_number     (out_ch.frame_number),
  .out_tlb_hit          (out_ch.tlb_hit),
  .out_page_fault       (out_ch.page_fault)
);
